// ----- rtl/dmm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dmm_pkg;

   // default sizes
   localparam int DMM_MAX_DIM    = 8;
   localparam int DMM_ELEM_WIDTH = 16;

   // fixed field widths of the channels
   localparam int FUNC_W      = 2;
   localparam int IDX_W       = 3;
   localparam int ELEM_IN_W   = 16;
   localparam int OUT_VALUE_W = 36;
   localparam int DIM_W       = 4;
   localparam int CSR_IDX_W   = 2;
   localparam int WIDE_W      = 64;

   // function codes of a request beat
   localparam logic [FUNC_W-1:0] FUNC_LOAD_A  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOAD_B  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

   // register indexes of the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_A    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_DIM = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_B    = 2'd2;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } dmm_state_type;

   // tag that travels with one product through the pipeline
   typedef struct packed {
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic             first;
      logic             eoe;
      logic             last;
   } dmm_meta_type;

   typedef struct packed {
      logic         valid;
      dmm_meta_type meta;
   } dmm_issue_type;

endpackage

`default_nettype wire

// ----- rtl/dmm_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface dmm_req_if;
   import dmm_pkg::*;
   logic                        valid;
   logic                        ready;
   logic [FUNC_W-1:0]           func;
   logic [IDX_W-1:0]            row_index;
   logic [IDX_W-1:0]            col_index;
   logic signed [ELEM_IN_W-1:0] elem_value;

   modport source (output valid, func, row_index, col_index, elem_value, input ready);
   modport sink (input valid, func, row_index, col_index, elem_value, output ready);
endinterface

interface dmm_rsp_if;
   import dmm_pkg::*;
   logic                          valid;
   logic                          ready;
   logic [IDX_W-1:0]              out_row;
   logic [IDX_W-1:0]              out_col;
   logic signed [OUT_VALUE_W-1:0] out_value;
   logic                          last;

   modport source (output valid, out_row, out_col, out_value, last, input ready);
   modport sink (input valid, out_row, out_col, out_value, last, output ready);
endinterface

`default_nettype wire

// ----- rtl/dense_matrix_multiply_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Dense matrix multiply C = A x B on signed Q8.8 elements. A load beat (func 0 for A,
// 1 for B) writes one element into the A or B store and returns nothing; loads outside
// MAX_DIM are dropped. A compute beat (func 2) walks rows, then columns, then the inner
// index, and emits the M*N elements of C in row-major order as exact Q20.16 sums, last
// set on the final one. The walk does one multiply-accumulate per cycle unless the
// result beat stalls, bound by the single read port of each store; a product passes the
// store read and product registers before its sum enters the output register. No new
// beat is taken until the walk has issued its last read. A stalled result beat holds
// the whole pipeline. Dimensions are written on the csr port (0 reads as 1, above
// MAX_DIM as MAX_DIM); the user must write them only while the block is idle, which
// the block does not enforce. Stores come up undefined; read only entries that were loaded.
module dense_matrix_multiply_core import dmm_pkg::*; #(
   parameter int MAX_DIM    = DMM_MAX_DIM,
   parameter int ELEM_WIDTH = DMM_ELEM_WIDTH
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DIM_W-1:0]     csr_wdata,
   dmm_req_if.sink                   req_ch,
   dmm_rsp_if.source                 rsp_ch
);

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = $clog2(DEPTH);

   logic                  a_we;
   logic                  b_we;
   logic [ADDR_W-1:0]     wr_addr;
   logic [ELEM_WIDTH-1:0] wr_data;
   logic                  rd_en;
   logic [ADDR_W-1:0]     a_rd_addr;
   logic [ADDR_W-1:0]     b_rd_addr;
   logic [ELEM_WIDTH-1:0] a_rdata;
   logic [ELEM_WIDTH-1:0] b_rdata;
   logic                  adv;
   dmm_issue_type         issue;

   // walk control, dimension registers and load path
   dmm_seq #(
      .MAX_DIM    (MAX_DIM),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .adv       (adv),
      .a_we      (a_we),
      .b_we      (b_we),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .a_rd_addr (a_rd_addr),
      .b_rd_addr (b_rd_addr),
      .issue     (issue)
   );

   // element store of A
   dmm_ram #(
      .WIDTH (ELEM_WIDTH),
      .DEPTH (DEPTH)
   ) u_a_store (
      .clock (clock),
      .we    (a_we),
      .waddr (wr_addr),
      .wdata (wr_data),
      .re    (rd_en),
      .raddr (a_rd_addr),
      .rdata (a_rdata)
   );

   // element store of B
   dmm_ram #(
      .WIDTH (ELEM_WIDTH),
      .DEPTH (DEPTH)
   ) u_b_store (
      .clock (clock),
      .we    (b_we),
      .waddr (wr_addr),
      .wdata (wr_data),
      .re    (rd_en),
      .raddr (b_rd_addr),
      .rdata (b_rdata)
   );

   // multiply, accumulate and output register
   dmm_mac #(
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_mac (
      .clock   (clock),
      .reset   (reset),
      .a_rdata (a_rdata),
      .b_rdata (b_rdata),
      .issue   (issue),
      .adv     (adv),
      .rsp_ch  (rsp_ch)
   );

endmodule

`default_nettype wire

// ----- rtl/dmm_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dmm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- rtl/dmm_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dmm_seq import dmm_pkg::*; #(
   parameter int MAX_DIM    = DMM_MAX_DIM,
   parameter int ELEM_WIDTH = DMM_ELEM_WIDTH
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_we,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [DIM_W-1:0]        csr_wdata,
   dmm_req_if.sink                      req_ch,
   input  wire logic                    adv,
   output logic                         a_we,
   output logic                         b_we,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] wr_addr,
   output logic [ELEM_WIDTH-1:0]        wr_data,
   output logic                         rd_en,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] a_rd_addr,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] b_rd_addr,
   output dmm_issue_type                issue
);

   localparam int ADDR_W    = $clog2(MAX_DIM * MAX_DIM);
   localparam int CNT_W     = $clog2(MAX_DIM);
   localparam int CMP_W     = (CNT_W > DIM_W) ? CNT_W : DIM_W;
   localparam int DIM_CAP   = (MAX_DIM < 15) ? MAX_DIM : 15;
   localparam int DIM_RESET = (DIM_CAP < 8) ? DIM_CAP : 8;

   dmm_state_type      state_ff, state_in;
   logic [DIM_W-1:0]   rows_ff, rows_in;
   logic [DIM_W-1:0]   inner_ff, inner_in;
   logic [DIM_W-1:0]   cols_ff, cols_in;
   logic [DIM_W-1:0]   csr_dim;
   logic [CNT_W-1:0]   r_ff, r_in;
   logic [CNT_W-1:0]   c_ff, c_in;
   logic [CNT_W-1:0]   k_ff, k_in;
   logic               r_last, c_last, k_last;
   logic               req_beat;
   logic               load_ok;
   logic signed [ELEM_IN_W-1:0] elem_in;

   // saturate a written dimension into 1..MAX_DIM, at most 15
   always_comb begin
      if (csr_wdata == '0) begin
         csr_dim = DIM_W'(1);
      end else if (int'(csr_wdata) > DIM_CAP) begin
         csr_dim = DIM_W'(DIM_CAP);
      end else begin
         csr_dim = csr_wdata;
      end
   end

   // dimension registers
   always_comb begin
      rows_in  = rows_ff;
      inner_in = inner_ff;
      cols_in  = cols_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ROWS_A:    rows_in  = csr_dim;
            CSR_INNER_DIM: inner_in = csr_dim;
            CSR_COLS_B:    cols_in  = csr_dim;
            default:       ;
         endcase
      end
   end

   // load beats write straight into the element stores
   assign req_beat = req_ch.valid && req_ch.ready;
   assign load_ok  = req_beat && (int'(req_ch.row_index) < MAX_DIM)
                     && (int'(req_ch.col_index) < MAX_DIM);
   assign elem_in  = req_ch.elem_value;
   assign a_we     = load_ok && (req_ch.func == FUNC_LOAD_A);
   assign b_we     = load_ok && (req_ch.func == FUNC_LOAD_B);
   assign wr_addr  = ADDR_W'(req_ch.row_index) * ADDR_W'(MAX_DIM)
                     + ADDR_W'(req_ch.col_index);
   assign wr_data  = ELEM_WIDTH'(elem_in);

   // end of each loop of the row, column, inner walk
   assign k_last = (CMP_W'(k_ff) + CMP_W'(1)) == CMP_W'(inner_ff);
   assign c_last = (CMP_W'(c_ff) + CMP_W'(1)) == CMP_W'(cols_ff);
   assign r_last = (CMP_W'(r_ff) + CMP_W'(1)) == CMP_W'(rows_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat && (req_ch.func == FUNC_COMPUTE)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (adv && k_last && c_last && r_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the walk control
   always_comb begin
      req_ch.ready     = 1'b0;
      issue.valid      = 1'b0;
      issue.meta.row   = IDX_W'(r_ff);
      issue.meta.col   = IDX_W'(c_ff);
      issue.meta.first = (k_ff == '0);
      issue.meta.eoe   = k_last;
      issue.meta.last  = k_last && c_last && r_last;
      unique case (state_ff)
         ST_IDLE: req_ch.ready = 1'b1;
         ST_RUN:  issue.valid  = adv;
         default: ;
      endcase
   end

   // row k of b and column k of a for the current output element
   assign rd_en     = issue.valid;
   assign a_rd_addr = ADDR_W'(r_ff) * ADDR_W'(MAX_DIM) + ADDR_W'(k_ff);
   assign b_rd_addr = ADDR_W'(k_ff) * ADDR_W'(MAX_DIM) + ADDR_W'(c_ff);

   // walk counters, inner index fastest
   always_comb begin
      r_in = r_ff;
      c_in = c_ff;
      k_in = k_ff;
      if (issue.valid) begin
         if (k_last) begin
            k_in = '0;
            if (c_last) begin
               c_in = '0;
               r_in = r_last ? '0 : r_ff + CNT_W'(1);
            end else begin
               c_in = c_ff + CNT_W'(1);
            end
         end else begin
            k_in = k_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rows_ff  <= DIM_W'(DIM_RESET);
         inner_ff <= DIM_W'(DIM_RESET);
         cols_ff  <= DIM_W'(DIM_RESET);
         r_ff     <= '0;
         c_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         rows_ff  <= rows_in;
         inner_ff <= inner_in;
         cols_ff  <= cols_in;
         r_ff     <= r_in;
         c_ff     <= c_in;
         k_ff     <= k_in;
      end
   end

`ifndef SYNTHESIS
   // the final product of a run ends the walk
   a_last_ends_walk: assert property (@(posedge clock) disable iff (reset)
      issue.valid && issue.meta.last |=> state_ff == ST_IDLE)
      else $error("walk continued after last product");

   // a stalled walk keeps its position
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) && !adv |=> $stable(r_ff) && $stable(c_ff) && $stable(k_ff))
      else $error("walk counters moved during stall");
`endif

endmodule

`default_nettype wire

// ----- rtl/dmm_mac.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dmm_mac import dmm_pkg::*; #(
   parameter int ELEM_WIDTH = DMM_ELEM_WIDTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [ELEM_WIDTH-1:0] a_rdata,
   input  wire logic [ELEM_WIDTH-1:0] b_rdata,
   input  wire dmm_issue_type         issue,
   output logic                       adv,
   dmm_rsp_if.source                  rsp_ch
);

   localparam int PROD_W = 2 * ELEM_WIDTH;

   logic                          s1_valid_ff;
   dmm_meta_type                  s1_meta_ff;
   logic                          s2_valid_ff;
   dmm_meta_type                  s2_meta_ff;
   logic signed [PROD_W-1:0]      prod_in, prod_ff;
   logic signed [WIDE_W-1:0]      prod_wide;
   logic [OUT_VALUE_W-1:0]        term;
   logic [OUT_VALUE_W-1:0]        acc_ff, acc_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]              rsp_row_ff;
   logic [IDX_W-1:0]              rsp_col_ff;
   logic [OUT_VALUE_W-1:0]        rsp_value_ff;
   logic                          rsp_last_ff;
   logic                          emit;

   // the whole pipeline moves only when the output register can take a beat
   assign adv = !rsp_valid_ff || rsp_ch.ready;

   // stage 2: signed product of the two store reads
   assign prod_in = PROD_W'(signed'(a_rdata)) * PROD_W'(signed'(b_rdata));

   // stage 3: accumulate modulo the output width
   assign prod_wide = WIDE_W'(prod_ff);
   assign term      = prod_wide[OUT_VALUE_W-1:0];
   assign acc_in    = (s2_meta_ff.first ? '0 : acc_ff) + term;
   assign emit      = s2_valid_ff && s2_meta_ff.eoe;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (adv) begin
         rsp_valid_in = emit;
      end
   end

   // valid flags of the stages
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            s1_valid_ff <= issue.valid;
            s2_valid_ff <= s1_valid_ff;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload of the stages
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_meta_ff <= issue.meta;
         s2_meta_ff <= s1_meta_ff;
         prod_ff    <= prod_in;
         if (s2_valid_ff) begin
            acc_ff <= acc_in;
         end
         if (emit) begin
            rsp_row_ff   <= s2_meta_ff.row;
            rsp_col_ff   <= s2_meta_ff.col;
            rsp_value_ff <= acc_in;
            rsp_last_ff  <= s2_meta_ff.last;
         end
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.out_row   = rsp_row_ff;
   assign rsp_ch.out_col   = rsp_col_ff;
   assign rsp_ch.out_value = signed'(rsp_value_ff);
   assign rsp_ch.last      = rsp_last_ff;

`ifndef SYNTHESIS
   // a product waiting in stage 1 survives a stall
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !adv |=> s1_valid_ff && $stable(s1_meta_ff))
      else $error("stage 1 lost its product during stall");

   // a finished element lands in the output register with its coordinates
   a_emit_coords: assert property (@(posedge clock) disable iff (reset)
      emit && adv |=> rsp_valid_ff && (rsp_row_ff == $past(s2_meta_ff.row))
                      && (rsp_col_ff == $past(s2_meta_ff.col)))
      else $error("finished element not presented");
`endif

endmodule

`default_nettype wire
